FILE: hdl/ostt_pkg.sv
package ostt_pkg;

    localparam int SLOT_W = 4;
    localparam int TAG_PORT_W = 16;
    localparam int TICK_W = 64;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [TAG_PORT_W-1:0] tag_t;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NOSLOT = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] timeout;
        tag_t        tag;
        slot_t       slot;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        slot_t      new_slot;
        logic       fired;
        slot_t      fired_slot;
        tag_t       fired_tag;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RESPOND
    } state_t;

    typedef enum logic [2:0] {
        RK_ZERO_ALL,
        RK_FIRED,
        RK_CREATED,
        RK_DELETED,
        RK_ZERO_TMO,
        RK_FULL,
        RK_NOSLOT
    } res_kind_t;

    typedef struct packed {
        logic      load_in;
        logic      inc_tick;
        logic      scan_clr;
        logic      scan_step;
        logic      respond;
        res_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       tmo_zero;
        logic       full;
        logic       slot_oob;
        logic       hit;
        logic       scan_last;
        logic       out_busy;
    } sts_t;

endpackage

FILE: hdl/ostt_ram.sv
module ostt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 10
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ostt_ctrl.sv
module ostt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ostt_pkg::sts_t  sts,
    output ostt_pkg::cmd_t  cmd
);

    ostt_pkg::state_t state_reg;
    ostt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ostt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ostt_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = ostt_pkg::S_DECODE;
                end
            end
            ostt_pkg::S_DECODE: begin
                if (sts.op == ostt_pkg::OP_TICK) begin
                    state_next = ostt_pkg::S_SCAN;
                end else begin
                    state_next = ostt_pkg::S_RESPOND;
                end
            end
            ostt_pkg::S_SCAN: begin
                if (sts.hit || sts.scan_last) begin
                    state_next = ostt_pkg::S_RESPOND;
                end
            end
            ostt_pkg::S_RESPOND: begin
                if (!sts.out_busy) begin
                    state_next = ostt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ostt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.kind = ostt_pkg::RK_ZERO_ALL;
        s_ready = 1'b0;
        case (state_reg)
            ostt_pkg::S_IDLE: begin
                s_ready = 1'b1;
                cmd.load_in = s_valid;
            end
            ostt_pkg::S_DECODE: begin
                if (sts.op == ostt_pkg::OP_TICK) begin
                    cmd.inc_tick = 1'b1;
                    cmd.scan_clr = 1'b1;
                end
            end
            ostt_pkg::S_SCAN: begin
                cmd.scan_step = !(sts.hit || sts.scan_last);
            end
            ostt_pkg::S_RESPOND: begin
                cmd.respond = !sts.out_busy;
                case (sts.op)
                    ostt_pkg::OP_TICK: begin
                        cmd.kind = sts.hit ? ostt_pkg::RK_FIRED : ostt_pkg::RK_ZERO_ALL;
                    end
                    ostt_pkg::OP_CREATE: begin
                        if (sts.tmo_zero) begin
                            cmd.kind = ostt_pkg::RK_ZERO_TMO;
                        end else if (sts.full) begin
                            cmd.kind = ostt_pkg::RK_FULL;
                        end else begin
                            cmd.kind = ostt_pkg::RK_CREATED;
                        end
                    end
                    ostt_pkg::OP_DELETE: begin
                        cmd.kind = sts.slot_oob ? ostt_pkg::RK_NOSLOT : ostt_pkg::RK_DELETED;
                    end
                    default: begin
                        cmd.kind = ostt_pkg::RK_ZERO_ALL;
                    end
                endcase
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/ostt_dp.sv
module ostt_dp #(
    parameter int SLOTS = 10,
    parameter int TAG_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ostt_pkg::in_item_t  s_data,
    input  ostt_pkg::cmd_t      cmd,
    output ostt_pkg::sts_t      sts,
    output logic                m_valid,
    input  logic                m_ready,
    output ostt_pkg::out_item_t m_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TAG_W = (TAG_BITS < ostt_pkg::TAG_PORT_W) ? TAG_BITS : ostt_pkg::TAG_PORT_W;
    localparam int RAM_W = ostt_pkg::TICK_W + TAG_W;

    ostt_pkg::in_item_t         in_reg;
    logic [ostt_pkg::TICK_W-1:0] tick_reg;
    logic [ostt_pkg::TICK_W-1:0] tick_next;
    logic [SLOTS-1:0]           active_reg;
    logic [SLOTS-1:0]           active_next;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic [IDX_W-1:0]           rd_idx_next;
    logic [IDX_W-1:0]           chk_idx_reg;
    logic [IDX_W-1:0]           chk_idx_next;
    logic                       chk_valid_reg;
    logic                       chk_valid_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    ostt_pkg::out_item_t        m_data_reg;
    ostt_pkg::out_item_t        m_data_next;

    logic [IDX_W-1:0]           free_idx;
    logic                       ram_we;
    logic [RAM_W-1:0]           ram_wdata;
    logic [RAM_W-1:0]           ram_rdata;
    logic [ostt_pkg::TICK_W-1:0] rd_expiry;
    logic [TAG_W-1:0]           rd_tag;
    logic                       hit;

    ostt_ram #(
        .WIDTH(RAM_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(free_idx),
        .wdata(ram_wdata),
        .re   (cmd.scan_step),
        .raddr(rd_idx_reg),
        .rdata(ram_rdata)
    );

    assign rd_expiry = ram_rdata[RAM_W-1 -: ostt_pkg::TICK_W];
    assign rd_tag    = ram_rdata[TAG_W-1:0];
    assign hit       = chk_valid_reg && active_reg[chk_idx_reg] && (tick_reg >= rd_expiry);

    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign ram_we    = cmd.respond && (cmd.kind == ostt_pkg::RK_CREATED);
    assign ram_wdata = {tick_reg + ostt_pkg::TICK_W'(in_reg.timeout), in_reg.tag[TAG_W-1:0]};

    assign sts.op        = in_reg.op;
    assign sts.tmo_zero  = (in_reg.timeout == '0);
    assign sts.full      = &active_reg;
    assign sts.slot_oob  = ({1'b0, in_reg.slot} >= (ostt_pkg::SLOT_W + 1)'(SLOTS));
    assign sts.hit       = hit;
    assign sts.scan_last = chk_valid_reg && (chk_idx_reg == IDX_W'(SLOTS - 1));
    assign sts.out_busy  = m_valid_reg && !m_ready;

    always_comb begin
        tick_next      = cmd.inc_tick ? tick_reg + 1'b1 : tick_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        if (cmd.scan_clr) begin
            rd_idx_next    = '0;
            chk_valid_next = 1'b0;
        end else if (cmd.scan_step) begin
            rd_idx_next    = rd_idx_reg + 1'b1;
            chk_idx_next   = rd_idx_reg;
            chk_valid_next = 1'b1;
        end
    end

    always_comb begin
        active_next = active_reg;
        for (int i = 0; i < SLOTS; i++) begin
            if (cmd.respond) begin
                case (cmd.kind)
                    ostt_pkg::RK_CREATED: begin
                        if (free_idx == IDX_W'(i)) begin
                            active_next[i] = 1'b1;
                        end
                    end
                    ostt_pkg::RK_FIRED: begin
                        if (chk_idx_reg == IDX_W'(i)) begin
                            active_next[i] = 1'b0;
                        end
                    end
                    ostt_pkg::RK_DELETED: begin
                        if (in_reg.slot == ostt_pkg::SLOT_W'(i)) begin
                            active_next[i] = 1'b0;
                        end
                    end
                    default: begin
                        active_next[i] = active_reg[i];
                    end
                endcase
            end
        end
    end

    always_comb begin
        m_data_next = '0;
        case (cmd.kind)
            ostt_pkg::RK_FIRED: begin
                m_data_next.fired      = 1'b1;
                m_data_next.fired_slot = ostt_pkg::slot_t'(chk_idx_reg);
                m_data_next.fired_tag  = ostt_pkg::tag_t'(rd_tag);
            end
            ostt_pkg::RK_CREATED: begin
                m_data_next.new_slot = ostt_pkg::slot_t'(free_idx);
            end
            ostt_pkg::RK_ZERO_TMO: begin
                m_data_next.status = ostt_pkg::ST_ZERO;
            end
            ostt_pkg::RK_FULL: begin
                m_data_next.status = ostt_pkg::ST_FULL;
            end
            ostt_pkg::RK_NOSLOT: begin
                m_data_next.status = ostt_pkg::ST_NOSLOT;
            end
            default: begin
                m_data_next.status = ostt_pkg::ST_OK;
            end
        endcase
        if (cmd.respond) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            active_reg    <= '0;
            rd_idx_reg    <= '0;
            chk_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            tick_reg      <= tick_next;
            active_reg    <= active_next;
            rd_idx_reg    <= rd_idx_next;
            chk_idx_reg   <= chk_idx_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.respond) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/one_shot_timer_table_unit.sv
// Table of SLOTS one-shot timers on a 64-bit tick counter, one item at a time. A tick item
// scans the expiry and tag RAM one slot per cycle until the lowest expired active slot is
// found or the last slot is checked; create and delete items skip the scan. The result waits
// in an output register, and a stalled result channel holds the block in its respond step.
module one_shot_timer_table_unit #(
    parameter int SLOTS = 10,
    parameter int TAG_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ostt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ostt_pkg::out_item_t m_data
);

    ostt_pkg::cmd_t cmd;
    ostt_pkg::sts_t sts;

    ostt_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    ostt_dp #(
        .SLOTS   (SLOTS),
        .TAG_BITS(TAG_BITS)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

FILE: hdl/ostt_checker.sv
module ostt_checker #(
    parameter int SLOTS = 10
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ostt_pkg::out_item_t m_data
);

    a_reset_clears_result: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result changed.");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Second item accepted while one is in progress.");

    a_fired_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.fired |->
            m_data.status == ostt_pkg::ST_OK && m_data.new_slot == '0 &&
            {1'b0, m_data.fired_slot} < (ostt_pkg::SLOT_W + 1)'(SLOTS))
        else $error("Fired result has a bad status or slot.");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ostt_pkg::ST_OK |->
            !m_data.fired && m_data.new_slot == '0 && m_data.fired_slot == '0 &&
            m_data.fired_tag == '0)
        else $error("Error result carries data.");

endmodule

bind one_shot_timer_table_unit ostt_checker #(.SLOTS(SLOTS)) u_ostt_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
